FILE: rtl/core/wsfr_pkg.sv
`timescale 1ns / 1ps
// Package for the WebSocket frame receiver core: result kinds, parse phases
// and the per-byte result plan passed from the parser to the output stage.
// No dependencies.
package wsfr_pkg;

  localparam int unsigned MaxResults = 7;
  localparam int unsigned LenWidth   = 63;

  typedef logic [2:0] res_cnt_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_PONG     = 3'd2,
    KIND_MASKED   = 3'd3,
    KIND_RESERVED = 3'd4,
    KIND_PINGLONG = 3'd5,
    KIND_SKIP     = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'b0001,
    PH_SECOND  = 4'b0010,
    PH_EXT     = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_e;

  localparam logic [3:0] OpcodePing    = 4'hA - 4'h1;
  localparam logic [3:0] OpcodePong    = 4'hA;
  localparam logic [7:0] FinBit        = 8'h80;
  localparam logic [7:0] RsvMask       = 8'h70;
  localparam logic [6:0] MaxCtrlLen    = 7'd125;
  localparam logic [3:0] ExtBytes16    = 4'd2;
  localparam logic [3:0] ExtBytes64    = 4'd8;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
  } entry_t;

  // Everything one received byte produces: up to seven results that share
  // opcode and length; frame_done applies to the last of them.
  typedef struct packed {
    res_cnt_t                   count;
    logic                       done;
    logic [3:0]                 opcode;
    logic [LenWidth-1:0]        plen;
    entry_t [MaxResults-1:0]    entries;
  } plan_t;

endpackage

FILE: rtl/core/wsfr_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the WebSocket frame receiver core.
// Depends on nothing; widths follow the received byte and result fields.
interface wsfr_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_in;
  logic        segment_start;
  logic [31:0] mask_key;

  modport source (output valid, output byte_in, output segment_start, output mask_key,
                  input ready);
  modport sink   (input valid, input byte_in, input segment_start, input mask_key,
                  output ready);
endinterface

interface wsfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [3:0]  frame_opcode;
  logic [7:0]  data_byte;
  logic [62:0] frame_length;
  logic        frame_done;
  logic        last;

  modport source (output valid, output result_kind, output frame_opcode, output data_byte,
                  output frame_length, output frame_done, output last, input ready);
  modport sink   (input valid, input result_kind, input frame_opcode, input data_byte,
                  input frame_length, input frame_done, input last, output ready);
endinterface

FILE: rtl/core/websocket_frame_receiver_core.sv
`timescale 1ns / 1ps
// WebSocket frame receiver core. Takes one received byte per transaction
// and returns header, payload, pong and error results. A byte is accepted
// at the same edge that takes the previous byte's last result, so a byte
// with one result keeps a rate of one byte per clock while the result port
// is ready; a byte with several results (seven for a ping header that
// launches a pong) holds the input until its last result is taken. The
// single result port, draining the result buffer one entry per cycle while
// ready, sets the byte rate. The first result is registered and appears in
// the cycle after acceptance. Depends on wsfr_pkg, wsfr_if and wsfr_parser.
module websocket_frame_receiver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfr_in_if.sink     rx_i,
  wsfr_out_if.source  res_o
);
  import wsfr_pkg::*;

  plan_t               plan;
  logic                accept;
  logic                pop;
  logic                last_w;

  entry_t              ent_q [MaxResults];
  res_cnt_t            cnt_q;
  res_cnt_t            idx_q;
  logic                done_q;
  logic [3:0]          opc_q;
  logic [LenWidth-1:0] plen_q;
  logic                valid_q;

  wsfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .byte_i      (rx_i.byte_in),
    .seg_start_i (rx_i.segment_start),
    .mask_key_i  (rx_i.mask_key),
    .plan_o      (plan)
  );

  assign last_w     = (idx_q == cnt_q - res_cnt_t'(1));
  assign pop        = valid_q && res_o.ready;
  assign rx_i.ready = !valid_q || (res_o.ready && last_w);
  assign accept     = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
      cnt_q   <= plan.count;
    end else if (pop) begin
      if (last_w) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + res_cnt_t'(1);
      end
    end
  end

  // result payload, loaded once per accepted byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      done_q <= plan.done;
      opc_q  <= plan.opcode;
      plen_q <= plan.plen;
      for (int i = 0; i < MaxResults; i++) begin
        ent_q[i] <= plan.entries[i];
      end
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.result_kind  = ent_q[idx_q].kind;
  assign res_o.data_byte    = ent_q[idx_q].data;
  assign res_o.frame_opcode = opc_q;
  assign res_o.frame_length = plen_q;
  assign res_o.last         = last_w;
  assign res_o.frame_done   = done_q && last_w;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < cnt_q))
    else $error("result index beyond buffered count");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (valid_q && idx_q == '0 && cnt_q != '0))
    else $error("accepted byte did not load results");

  a_drain_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last_w) |=> (valid_q && idx_q == $past(idx_q) + res_cnt_t'(1)))
    else $error("result buffer did not advance on pop");

  a_pong_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && plan.count == res_cnt_t'(MaxResults)) |-> (plan.plen <= LenWidth'(MaxCtrlLen)))
    else $error("pong launched for oversize ping");
`endif

endmodule

FILE: rtl/core/wsfr_parser.sv
`timescale 1ns / 1ps
// Frame header parser: holds the parse state and turns each received byte
// into a result plan. Depends on wsfr_pkg.
module wsfr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              seg_start_i,
  input  logic [31:0]       mask_key_i,
  output wsfr_pkg::plan_t   plan_o
);
  import wsfr_pkg::*;

  phase_e              phase_q, phase_d;
  logic [7:0]          first_q, first_d;
  logic [LenWidth-1:0] len_q, len_d;
  logic [3:0]          ext_q, ext_d;
  logic [LenWidth-1:0] pl_q, pl_d;
  logic [31:0]         key_q, key_d;
  logic [1:0]          kidx_q, kidx_d;
  logic                pong_q, pong_d;
  logic                skip_q, skip_d;

  phase_e              phase_e_w;
  logic                skip_e, pong_e;
  logic                hc;
  logic [LenWidth-1:0] hc_len;
  logic [LenWidth-1:0] new_len;
  logic [LenWidth-1:0] pl_dec;
  logic [3:0]          ext_dec;
  plan_t               plan;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = key[31:24];
      2'd1:    r = key[23:16];
      2'd2:    r = key[15:8];
      default: r = key[7:0];
    endcase
    return r;
  endfunction

  assign new_len = {len_q[LenWidth-9:0], byte_i};
  assign pl_dec  = pl_q - LenWidth'(pl_q != '0);
  assign ext_dec = ext_q - 4'(ext_q != 4'd0);

  always_comb begin
    // segment start restarts parsing before the byte is looked at
    phase_e_w = seg_start_i ? PH_FIRST : phase_q;
    skip_e    = seg_start_i ? 1'b0 : skip_q;
    pong_e    = seg_start_i ? 1'b0 : pong_q;

    phase_d = phase_e_w;
    skip_d  = skip_e;
    pong_d  = pong_e;
    first_d = first_q;
    len_d   = len_q;
    ext_d   = ext_q;
    pl_d    = pl_q;
    key_d   = key_q;
    kidx_d  = kidx_q;
    hc      = 1'b0;
    hc_len  = '0;

    plan                  = '0;
    plan.count            = res_cnt_t'(1);
    plan.opcode           = first_q[3:0];
    plan.plen             = len_q;
    plan.entries[0].kind  = KIND_SKIP;
    plan.entries[0].data  = byte_i;

    if (!skip_e) begin
      unique case (phase_e_w)
        PH_FIRST: begin
          first_d              = byte_i;
          len_d                = '0;
          ext_d                = 4'd0;
          pl_d                 = '0;
          pong_d               = 1'b0;
          phase_d              = PH_SECOND;
          plan.opcode          = byte_i[3:0];
          plan.plen            = '0;
          plan.entries[0].kind = KIND_HEADER;
        end
        PH_SECOND: begin
          if (byte_i[7]) begin
            plan.entries[0].kind = KIND_MASKED;
            plan.done            = 1'b1;
            skip_d               = 1'b1;
          end else if ((first_q & RsvMask) != 8'h00) begin
            plan.entries[0].kind = KIND_RESERVED;
            plan.done            = 1'b1;
            skip_d               = 1'b1;
          end else if (byte_i[6:1] == 6'b111111) begin
            // 126 or 127: extended length follows
            len_d                = '0;
            ext_d                = byte_i[0] ? ExtBytes64 : ExtBytes16;
            phase_d              = PH_EXT;
            plan.plen            = '0;
            plan.entries[0].kind = KIND_HEADER;
          end else begin
            hc     = 1'b1;
            hc_len = LenWidth'(byte_i[6:0]);
          end
        end
        PH_EXT: begin
          len_d     = new_len;
          ext_d     = ext_dec;
          plan.plen = new_len;
          if (ext_dec == 4'd0) begin
            hc     = 1'b1;
            hc_len = new_len;
          end else begin
            plan.entries[0].kind = KIND_HEADER;
          end
        end
        PH_PAYLOAD: begin
          plan.entries[0].kind = KIND_PAYLOAD;
          if (pong_e) begin
            plan.count           = res_cnt_t'(2);
            plan.entries[1].kind = KIND_PONG;
            plan.entries[1].data = byte_i ^ key_byte(key_q, kidx_q);
            kidx_d               = kidx_q + 2'd1;
          end
          pl_d = pl_dec;
          if (pl_dec == '0) begin
            plan.done = 1'b1;
            skip_d    = 1'b1;
            pong_d    = 1'b0;
          end
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end

    if (hc) begin
      len_d                = hc_len;
      pl_d                 = hc_len;
      plan.plen            = hc_len;
      plan.entries[0].kind = KIND_HEADER;
      pong_d               = 1'b0;
      if (first_q[3:0] == OpcodePing) begin
        if (hc_len <= LenWidth'(MaxCtrlLen)) begin
          pong_d               = 1'b1;
          key_d                = mask_key_i;
          kidx_d               = 2'd0;
          plan.count           = res_cnt_t'(MaxResults);
          plan.entries[1].kind = KIND_PONG;
          plan.entries[1].data = FinBit | {4'h0, OpcodePong};
          plan.entries[2].kind = KIND_PONG;
          plan.entries[2].data = FinBit | {1'b0, hc_len[6:0]};
          for (int i = 0; i < 4; i++) begin
            plan.entries[3+i].kind = KIND_PONG;
            plan.entries[3+i].data = key_byte(mask_key_i, 2'(i));
          end
        end else begin
          plan.count           = res_cnt_t'(2);
          plan.entries[1].kind = KIND_PINGLONG;
          plan.entries[1].data = 8'h00;
        end
      end
      if (hc_len == '0) begin
        plan.done = 1'b1;
        skip_d    = 1'b1;
        pong_d    = 1'b0;
      end else begin
        phase_d = PH_PAYLOAD;
      end
    end
  end

  assign plan_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      first_q <= '0;
      len_q   <= '0;
      ext_q   <= '0;
      pl_q    <= '0;
      key_q   <= '0;
      kidx_q  <= '0;
      pong_q  <= 1'b0;
      skip_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
      len_q   <= len_d;
      ext_q   <= ext_d;
      pl_q    <= pl_d;
      key_q   <= key_d;
      kidx_q  <= kidx_d;
      pong_q  <= pong_d;
      skip_q  <= skip_d;
    end
  end

endmodule

FILE: test/wsfr_checker.sv
`timescale 1ns / 1ps
// Result checker for the WebSocket frame receiver core: watches both channels,
// predicts the results of every accepted byte and compares them in order.
// Depends on wsfr_pkg and wsfr_if.
module wsfr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsfr_in_if          rx_i,
  wsfr_out_if         res_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import wsfr_pkg::*;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  opcode;
    logic [7:0]  data;
    logic [62:0] plen;
    logic        done;
    logic        last;
  } ws_result_t;

  ws_result_t frame_results_q[$];
  ws_result_t byte_results [MaxResults];
  int unsigned n_byte_res;
  int unsigned mismatches;
  int unsigned n_checked;

  // parser state mirror
  phase_e      phase;
  logic [7:0]  hdr0;
  logic [63:0] len_acc;
  logic [3:0]  ext_left;
  logic [62:0] pay_left;
  logic [31:0] pong_key;
  logic [1:0]  key_idx;
  logic        pong_on;
  logic        skipping;

  task automatic clear_parser();
    phase    = PH_FIRST;
    hdr0     = '0;
    len_acc  = '0;
    ext_left = '0;
    pay_left = '0;
    pong_key = '0;
    key_idx  = '0;
    pong_on  = 1'b0;
    skipping = 1'b0;
  endtask

  task automatic add_result(input kind_e k, input logic [7:0] d);
    if (n_byte_res < MaxResults) begin
      byte_results[n_byte_res] = '{kind: k, opcode: hdr0[3:0], data: d,
                                   plen: len_acc[62:0], done: 1'b0, last: 1'b0};
      n_byte_res++;
    end
  endtask

  task automatic end_frame();
    byte_results[n_byte_res-1].done = 1'b1;
    skipping = 1'b1;
    pong_on  = 1'b0;
  endtask

  task automatic header_done(input logic [7:0] b, input logic [31:0] key);
    pay_left = len_acc[62:0];
    add_result(KIND_HEADER, b);
    pong_on = 1'b0;
    if (hdr0[3:0] == OpcodePing) begin
      if (pay_left <= 63'(MaxCtrlLen)) begin
        pong_on  = 1'b1;
        pong_key = key;
        key_idx  = '0;
        add_result(KIND_PONG, FinBit | {4'h0, OpcodePong});
        add_result(KIND_PONG, {1'b1, pay_left[6:0]});
        for (int i = 0; i < 4; i++) add_result(KIND_PONG, pong_key[8*(3-i) +: 8]);
      end else begin
        add_result(KIND_PINGLONG, 8'h00);
      end
    end
    if (pay_left == '0) end_frame();
    else phase = PH_PAYLOAD;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic seg, input logic [31:0] key);
    n_byte_res = 0;
    if (seg) begin
      phase    = PH_FIRST;
      skipping = 1'b0;
      pong_on  = 1'b0;
    end
    if (skipping) begin
      add_result(KIND_SKIP, b);
    end else begin
      case (phase)
        PH_FIRST: begin
          hdr0     = b;
          len_acc  = '0;
          ext_left = '0;
          pay_left = '0;
          pong_on  = 1'b0;
          add_result(KIND_HEADER, b);
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          // mask bit is tested before the reserved bits
          if (b[7]) begin
            add_result(KIND_MASKED, b);
            end_frame();
          end else if ((hdr0 & RsvMask) != '0) begin
            add_result(KIND_RESERVED, b);
            end_frame();
          end else if (b[6:0] == LenCode16 || b[6:0] == LenCode64) begin
            len_acc  = '0;
            ext_left = (b[6:0] == LenCode16) ? ExtBytes16 : ExtBytes64;
            phase    = PH_EXT;
            add_result(KIND_HEADER, b);
          end else begin
            len_acc = {57'd0, b[6:0]};
            header_done(b, key);
          end
        end
        PH_EXT: begin
          len_acc = {len_acc[55:0], b};
          if (ext_left != '0) ext_left = ext_left - 4'd1;
          if (ext_left == '0) header_done(b, key);
          else add_result(KIND_HEADER, b);
        end
        default: begin
          add_result(KIND_PAYLOAD, b);
          if (pong_on) begin
            add_result(KIND_PONG, b ^ pong_key[8*(3-int'(key_idx)) +: 8]);
            key_idx = key_idx + 2'd1;
          end
          if (pay_left != '0) pay_left = pay_left - 63'd1;
          if (pay_left == '0) end_frame();
        end
      endcase
    end
    byte_results[n_byte_res-1].last = 1'b1;
    for (int i = 0; i < n_byte_res; i++) frame_results_q.push_back(byte_results[i]);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  task automatic check_result();
    ws_result_t exp_r;
    if (frame_results_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, got kind %0d data %0h",
               $time, res_i.result_kind, res_i.data_byte);
    end else begin
      exp_r = frame_results_q.pop_front();
      check_field("result_kind", 64'(exp_r.kind), 64'(res_i.result_kind));
      check_field("frame_opcode", 64'(exp_r.opcode), 64'(res_i.frame_opcode));
      check_field("data_byte", 64'(exp_r.data), 64'(res_i.data_byte));
      check_field("frame_length", 64'(exp_r.plen), 64'(res_i.frame_length));
      check_field("frame_done", 64'(exp_r.done), 64'(res_i.frame_done));
      check_field("last", 64'(exp_r.last), 64'(res_i.last));
    end
    n_checked++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      frame_results_q.delete();
      mismatches = 0;
      n_checked  = 0;
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // a byte's results start in the cycle after its transaction
      if (rx_i.valid && rx_i.ready)
        predict_byte(rx_i.byte_in, rx_i.segment_start, rx_i.mask_key);
      if (res_i.valid && res_i.ready) check_result();
      errors_o  <= mismatches;
      pending_o <= frame_results_q.size();
      checked_o <= n_checked;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the WebSocket frame receiver regression: clock, reset, byte stimulus
// with random gaps and result backpressure, and the verdict.
// Depends on wsfr_pkg, wsfr_if, websocket_frame_receiver_core and wsfr_checker.
module testbench;
  import wsfr_pkg::*;

  localparam int unsigned DirectedBytes = 25;
  localparam int unsigned RandomBytes   = 405;
  localparam logic [6:0]  LenCode16     = 7'd126;
  localparam logic [6:0]  LenCode64     = 7'd127;
  localparam logic [3:0]  OpCont        = 4'h0;
  localparam logic [3:0]  OpText        = 4'h1;
  localparam logic [3:0]  OpBinary      = 4'h2;
  localparam logic [3:0]  OpClose       = 4'h8;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wsfr_in_if  rx ();
  wsfr_out_if res ();

  int unsigned errors, pending, checked;
  int unsigned bytes_sent, segments, pings, sink_wait;
  bit          src_burst, sink_burst;

  websocket_frame_receiver_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .res_o  (res)
  );

  wsfr_checker chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx),
    .res_i     (res),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked)
  );

  always #1 clk_i = ~clk_i;

  // result backpressure: a random stall after every result transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (res.valid && res.ready) begin
        if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
        sink_wait = sink_burst ? 0 : $urandom_range(0, 15);
      end
      if (sink_wait > 0) begin
        res.ready <= 1'b0;
        sink_wait--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic seg);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx.valid         <= 1'b1;
    rx.byte_in       <= b;
    rx.segment_start <= seg;
    rx.mask_key      <= $urandom();
    do @(posedge clk_i); while (!rx.ready);
    bytes_sent++;
  endtask

  // header, then n_pay payload bytes, then n_tail more bytes of the segment
  task automatic send_frame(input logic [7:0] b0, input logic mbit, input len_form_e form,
                            input logic [63:0] len, input int n_pay, input int n_tail);
    segments++;
    if (b0[3:0] == OpcodePing) pings++;
    send_byte(b0, 1'b1);
    case (form)
      LEN_SHORT: send_byte({mbit, len[6:0]}, 1'b0);
      LEN_EXT16: begin
        send_byte({mbit, LenCode16}, 1'b0);
        send_byte(len[15:8], 1'b0);
        send_byte(len[7:0], 1'b0);
      end
      default: begin
        send_byte({mbit, LenCode64}, 1'b0);
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0);
      end
    endcase
    repeat (n_pay + n_tail) send_byte(8'($urandom()), 1'b0);
  endtask

  task automatic wait_drained();
    rx.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [3:0] pick_opcode();
    if ($urandom_range(0, 4) < 2) return OpcodePing;
    case ($urandom_range(0, 5))
      0: return OpCont;
      1: return OpText;
      2: return OpBinary;
      3: return OpClose;
      4: return OpcodePong;
      default: return 4'($urandom());
    endcase
  endfunction

  task automatic send_good_frame();
    logic [7:0]  b0;
    logic [63:0] len;
    len_form_e   form;
    int          n_pay, n_tail, pick;
    b0   = {1'($urandom()), 3'b000, pick_opcode()};
    pick = $urandom_range(0, 99);
    form = (pick < 70) ? LEN_SHORT : (pick < 85) ? LEN_EXT16 : LEN_EXT64;
    len  = 64'($urandom_range(0, 8));
    if (form == LEN_SHORT && $urandom_range(0, 19) == 0) len = 64'($urandom_range(120, 125));
    n_pay  = int'(len);
    n_tail = $urandom_range(0, 2);
    // unfinished frames get dropped by the next segment
    if (len > 12 || $urandom_range(0, 4) == 0) begin
      n_pay  = $urandom_range(0, (len > 6) ? 6 : int'(len));
      n_tail = 0;
    end
    send_frame(b0, 1'b0, form, len, n_pay, n_tail);
  endtask

  task automatic send_big_frame();
    logic [7:0]  b0;
    logic [63:0] len;
    len_form_e   form;
    b0 = {1'b1, 3'b000, ($urandom_range(0, 1) == 0) ? OpcodePing : pick_opcode()};
    if ($urandom_range(0, 1) == 0) begin
      form = LEN_EXT16;
      len  = 64'($urandom_range(126, 65535));
    end else begin
      form = LEN_EXT64;
      len  = {$urandom(), $urandom()};
    end
    send_frame(b0, 1'b0, form, len, $urandom_range(0, 4), 0);
  endtask

  task automatic send_bad_frame();
    logic [7:0] b0;
    logic       mbit;
    b0   = 8'($urandom());
    mbit = 1'($urandom());
    if (!mbit && b0[6:4] == 3'b000) mbit = 1'b1;
    send_frame(b0, mbit, LEN_SHORT, 64'($urandom_range(0, 127)), 0, $urandom_range(0, 3));
  endtask

  initial begin
    bit drained_mid;
    int pick;
    rx.valid         = 1'b0;
    rx.byte_in       = '0;
    rx.segment_start = 1'b0;
    rx.mask_key      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // header taken without segment_start right after reset
    send_byte(8'h81, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    // mask and reserved faults together, then reserved alone
    send_frame(8'hF1, 1'b1, LEN_SHORT, 64'd5, 0, 0);
    send_frame(8'hC2, 1'b0, LEN_SHORT, 64'd1, 0, 0);
    // short ping with pong, then an oversized ping whose payload still flows
    send_frame({FinBit[7:4], OpcodePing}, 1'b0, LEN_SHORT, 64'd1, 1, 0);
    send_frame({FinBit[7:4], OpcodePing}, 1'b0, LEN_EXT16, 64'd126, 1, 0);
    // 64-bit length with only the top bit set: ignored, so zero length
    send_frame(8'h82, 1'b0, LEN_EXT64, 64'h8000_0000_0000_0000, 0, 0);
    wait_drained();

    drained_mid = 1'b0;
    while (bytes_sent < DirectedBytes + RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) send_good_frame();
      else if (pick < 70) send_big_frame();
      else if (pick < 85) send_bad_frame();
      else repeat ($urandom_range(1, 6)) send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
      if (!drained_mid && bytes_sent > DirectedBytes + RandomBytes / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("sent %0d bytes over %0d framed segments (%0d pings), checked %0d results",
             bytes_sent, segments, pings, checked);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // far beyond the slowest legal run with full stalls on both sides
  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
